/* hw/rtl/bounded_deque_with_search_remove_top_defines.svh */
// assertion macros for the bounded deque
`ifndef BOUNDED_DEQUE_WITH_SEARCH_REMOVE_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_REMOVE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BDQ_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BDQ_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bdq_pkg.sv */
// shared constants, types and helpers for the bounded deque
package bdq_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = ADDR_W + 1;
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

    // upper two mode bits pick the operation, the low bit picks the tail end
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } ram_req_t;

    typedef struct packed {
        logic               vld;
        logic [VALUE_W-1:0] result_value;
        status_t            status;
        logic [CNT_W-1:0]   occupancy;
    } resp_t;

    // physical slot of the entry at logical position pos from the head
    function automatic logic [ADDR_W-1:0] slot_of(
        input logic [ADDR_W-1:0] head,
        input logic [ADDR_W-1:0] pos
    );
        logic [SUM_W-1:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

/* hw/rtl/bdq_req_if.sv */
// request channel interface
interface bdq_req_if;
    logic                        valid;
    logic                        ready;
    logic [bdq_pkg::MODE_W-1:0]  mode;
    logic [bdq_pkg::VALUE_W-1:0] value;
    logic [bdq_pkg::IDX_W-1:0]   index;

    modport source (output valid, output mode, output value, output index, input ready);
    modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

/* hw/rtl/bdq_rsp_if.sv */
// response channel interface
interface bdq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::VALUE_W-1:0]   result_value;
    logic [bdq_pkg::STATUS_W-1:0]  status;
    logic [bdq_pkg::CNT_W-1:0]     occupancy;

    modport source (output valid, output result_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input result_value, input status, input occupancy,
                    output ready);
endinterface

/* hw/rtl/bdq_ram.sv */
// generic single-write, single-read ram with registered read data
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bdq_ctrl.sv */
// request sequencer: head and count, ram access, search scan and gap close
module bdq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [bdq_pkg::MODE_W-1:0]  req_mode,
    input  logic [bdq_pkg::VALUE_W-1:0] req_value,
    input  logic [bdq_pkg::IDX_W-1:0]   req_index,
    input  logic [bdq_pkg::VALUE_W-1:0] rd_data,
    input  logic                        out_free,
    output bdq_pkg::ram_req_t           mem,
    output bdq_pkg::resp_t              resp
);
    import bdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t             state_reg,     state_next;
    logic [ADDR_W-1:0]  head_reg,      head_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [MODE_W-1:0]  mode_reg,      mode_next;
    logic [VALUE_W-1:0] value_reg,     value_next;
    logic [IDX_W-1:0]   index_reg,     index_next;
    logic [ADDR_W-1:0]  scan_pos_reg,  scan_pos_next;
    logic [CNT_W-1:0]   scan_left_reg, scan_left_next;
    logic [ADDR_W-1:0]  cmp_pos_reg,   cmp_pos_next;
    logic               cmp_vld_reg,   cmp_vld_next;
    logic [CNT_W-1:0]   rd_pos_reg,    rd_pos_next;
    logic [ADDR_W-1:0]  wpos_reg,      wpos_next;
    logic               wpend_reg,     wpend_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    status_t            status_reg,    status_next;

    op_t               op;
    logic              tail;
    logic [CNT_W-1:0]  cnt_dec;
    logic [CNT_W-1:0]  peek_tail;
    logic [CNT_W-1:0]  rd_pos_dec;
    logic [CNT_W-1:0]  hit_next_pos;
    logic [ADDR_W-1:0] head_dec;
    logic              hit;
    logic              issue;

    assign op           = op_t'(mode_reg[MODE_W-1:1]);
    assign tail         = mode_reg[0];
    assign cnt_dec      = count_reg - CNT_W'(1);
    assign peek_tail    = cnt_dec - CNT_W'(index_reg);
    assign rd_pos_dec   = rd_pos_reg - CNT_W'(1);
    assign hit_next_pos = CNT_W'(cmp_pos_reg) + CNT_W'(1);
    assign head_dec     = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    assign hit          = cmp_vld_reg && (rd_data == value_reg);
    assign issue        = rd_pos_reg < count_reg;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        value_next     = value_reg;
        index_next     = index_reg;
        scan_pos_next  = scan_pos_reg;
        scan_left_next = scan_left_reg;
        cmp_pos_next   = cmp_pos_reg;
        cmp_vld_next   = cmp_vld_reg;
        rd_pos_next    = rd_pos_reg;
        wpos_next      = wpos_reg;
        wpend_next     = wpend_reg;
        res_value_next = res_value_reg;
        status_next    = status_reg;
        mem            = '0;
        resp           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next  = req_mode;
                    value_next = req_value;
                    index_next = req_index;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_value_next = '0;
                status_next    = ST_OK;
                unique case (op)
                    OP_PUSH:
                    begin
                        state_next = S_RESP;
                        if (value_reg == '0)
                        begin
                            status_next = ST_ZERO;
                        end
                        else if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem.we     = 1'b1;
                            mem.wdata  = value_reg;
                            count_next = count_reg + CNT_W'(1);
                            if (tail)
                            begin
                                mem.waddr = slot_of(head_reg, count_reg[ADDR_W-1:0]);
                            end
                            else
                            begin
                                mem.waddr = head_dec;
                                head_next = head_dec;
                            end
                        end
                    end

                    OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_MISS;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            mem.re     = 1'b1;
                            count_next = cnt_dec;
                            state_next = S_RDATA;
                            if (tail)
                            begin
                                mem.raddr = slot_of(head_reg, cnt_dec[ADDR_W-1:0]);
                            end
                            else
                            begin
                                mem.raddr = head_reg;
                                head_next = slot_of(head_reg, ADDR_W'(1));
                            end
                        end
                    end

                    OP_PEEK:
                    begin
                        if (CNT_W'(index_reg) >= count_reg)
                        begin
                            status_next = ST_MISS;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            mem.re     = 1'b1;
                            state_next = S_RDATA;
                            mem.raddr  = tail ? slot_of(head_reg, peek_tail[ADDR_W-1:0])
                                              : slot_of(head_reg, ADDR_W'(index_reg));
                        end
                    end

                    OP_REMOVE:
                    begin
                        if (value_reg == '0)
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            scan_pos_next  = tail ? cnt_dec[ADDR_W-1:0] : '0;
                            scan_left_next = count_reg;
                            cmp_vld_next   = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                endcase
            end

            S_RDATA:
            begin
                res_value_next = rd_data;
                state_next     = S_RESP;
            end

            // reads go out one a cycle, each compared in the next cycle
            S_SCAN:
            begin
                if (hit)
                begin
                    res_value_next = value_reg;
                    if (hit_next_pos < count_reg)
                    begin
                        rd_pos_next = hit_next_pos;
                        wpend_next  = 1'b0;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        count_next = cnt_dec;
                        state_next = S_RESP;
                    end
                end
                else if (scan_left_reg == '0)
                begin
                    status_next = ST_MISS;
                    state_next  = S_RESP;
                end
                else
                begin
                    mem.re         = 1'b1;
                    mem.raddr      = slot_of(head_reg, scan_pos_reg);
                    cmp_pos_next   = scan_pos_reg;
                    cmp_vld_next   = 1'b1;
                    scan_pos_next  = tail ? scan_pos_reg - ADDR_W'(1)
                                          : scan_pos_reg + ADDR_W'(1);
                    scan_left_next = scan_left_reg - CNT_W'(1);
                end
            end

            // read entry k+1 while the word read last cycle lands one place nearer the head
            S_SHIFT:
            begin
                if (wpend_reg)
                begin
                    mem.we    = 1'b1;
                    mem.waddr = slot_of(head_reg, wpos_reg);
                    mem.wdata = rd_data;
                end
                wpend_next = issue;
                if (issue)
                begin
                    mem.re      = 1'b1;
                    mem.raddr   = slot_of(head_reg, rd_pos_reg[ADDR_W-1:0]);
                    wpos_next   = rd_pos_dec[ADDR_W-1:0];
                    rd_pos_next = rd_pos_reg + CNT_W'(1);
                end
                else
                begin
                    count_next = cnt_dec;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    resp.vld          = 1'b1;
                    resp.result_value = res_value_reg;
                    resp.status       = status_reg;
                    resp.occupancy    = count_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            mode_reg      <= '0;
            value_reg     <= '0;
            index_reg     <= '0;
            scan_pos_reg  <= '0;
            scan_left_reg <= '0;
            cmp_pos_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            rd_pos_reg    <= '0;
            wpos_reg      <= '0;
            wpend_reg     <= 1'b0;
            res_value_reg <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            value_reg     <= value_next;
            index_reg     <= index_next;
            scan_pos_reg  <= scan_pos_next;
            scan_left_reg <= scan_left_next;
            cmp_pos_reg   <= cmp_pos_next;
            cmp_vld_reg   <= cmp_vld_next;
            rd_pos_reg    <= rd_pos_next;
            wpos_reg      <= wpos_next;
            wpend_reg     <= wpend_next;
            res_value_reg <= res_value_next;
            status_reg    <= status_next;
        end
    end

endmodule

/* hw/rtl/bounded_deque_with_search_remove_top.sv */
// bounded deque with search-remove: entry ram, sequencer and output word register
// push and rejected requests pass S_EXEC then S_RESP; pop and peek add S_RDATA for the ram read
// search-remove: S_SCAN over the entries scanned, then S_SHIFT over the entries moved (skipped when none move)
// one request in work at a time; the next is taken after the output word loads
// a waiting output word stalls the sequencer only when the next response is due
// reset clears head, count, sequencer and output valid; the entry ram is not cleared
`include "bounded_deque_with_search_remove_top_defines.svh"

module bounded_deque_with_search_remove_top (
    input  logic       clk,
    input  logic       rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp
);
    import bdq_pkg::*;

    ram_req_t           mem;
    resp_t              resp;
    logic [VALUE_W-1:0] rd_data;
    logic               ctrl_ready;
    logic               out_free;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;
    logic [CNT_W-1:0]   out_occ_reg,   out_occ_next;

    bdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr),
        .rdata (rd_data)
    );

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctrl_ready),
        .req_mode  (req.mode),
        .req_value (req.value),
        .req_index (req.index),
        .rd_data   (rd_data),
        .out_free  (out_free),
        .mem       (mem),
        .resp      (resp)
    );

    assign req.ready = ctrl_ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        if (resp.vld)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = resp.result_value;
            out_status_next = resp.status;
            out_occ_next    = resp.occupancy;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
            out_occ_reg    <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.occupancy    = out_occ_reg;

    `BDQ_ASSERT_NOW(a_resp_into_free_slot, resp.vld, out_free, "response with output word occupied")
    `BDQ_ASSERT_NOW(a_occ_bound, out_valid_reg, out_occ_reg <= CNT_W'(DEPTH), "occupancy over depth")
    `BDQ_ASSERT_NOW(a_reject_zero_word, out_valid_reg && (out_status_reg != ST_OK), out_value_reg == '0, "rejected request carries a word")
    `BDQ_ASSERT_NEXT(a_no_accept_in_work, req.valid && req.ready, !req.ready, "request taken while busy")

endmodule

/* dv/tb_top.sv */
// testbench for the bounded deque with search-remove: shadow deque, scoreboard and drivers
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam bit END_HEAD     = 1'b0;
    localparam bit END_TAIL     = 1'b1;
    localparam int MAX_IDLE     = 16;
    localparam int RANDOM_WORDS = 1530;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic [VALUE_W-1:0] result_value;
        status_t            status;
        logic [CNT_W-1:0]   occupancy;
    } deque_reply_t;

    // shadow copy of the deque: each accepted request updates it and queues the reply it owes
    class deque_scoreboard;
        logic [VALUE_W-1:0] slots [DEPTH];
        int unsigned        head_slot;
        int unsigned        held;
        deque_reply_t       owed_replies [$];
        int unsigned        errors;

        function new();
            head_slot = 0;
            held      = 0;
            errors    = 0;
        endfunction

        function int unsigned slot_at(int unsigned pos);
            return (head_slot + pos) % DEPTH;
        endfunction

        function logic [VALUE_W-1:0] word_at(int unsigned pos);
            return slots[slot_at(pos)];
        endfunction

        function int unsigned owed();
            return owed_replies.size();
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                                   logic [IDX_W-1:0] index);
            deque_reply_t reply;
            op_t          op;
            bit           from_tail;
            bit           found;
            int unsigned  pos;

            op                 = op_t'(mode[2:1]);
            from_tail          = mode[0];
            reply.result_value = '0;
            reply.status       = ST_OK;
            found              = 1'b0;
            pos                = 0;
            case (op)
                OP_PUSH:
                begin
                    if (value == '0)
                        reply.status = ST_ZERO;
                    else if (held >= DEPTH)
                        reply.status = ST_FULL;
                    else if (from_tail)
                    begin
                        slots[slot_at(held)] = value;
                        held++;
                    end
                    else
                    begin
                        head_slot        = (head_slot + DEPTH - 1) % DEPTH;
                        slots[head_slot] = value;
                        held++;
                    end
                end
                OP_POP:
                begin
                    if (held == 0)
                        reply.status = ST_MISS;
                    else if (from_tail)
                    begin
                        reply.result_value = word_at(held - 1);
                        held--;
                    end
                    else
                    begin
                        reply.result_value = slots[head_slot];
                        head_slot          = slot_at(1);
                        held--;
                    end
                end
                OP_PEEK:
                begin
                    if (index >= held)
                        reply.status = ST_MISS;
                    else if (from_tail)
                        reply.result_value = word_at(held - 1 - index);
                    else
                        reply.result_value = word_at(index);
                end
                default:
                begin
                    if (value == '0)
                        reply.status = ST_ZERO;
                    else
                    begin
                        // first match seen from the chosen end
                        for (int unsigned k = 0; k < held && !found; k++)
                        begin
                            pos = from_tail ? held - 1 - k : k;
                            if (word_at(pos) == value)
                                found = 1'b1;
                        end
                        if (!found)
                            reply.status = ST_MISS;
                        else
                        begin
                            reply.result_value = value;
                            // close the gap towards the head
                            for (int unsigned k = pos; k + 1 < held; k++)
                                slots[slot_at(k)] = word_at(k + 1);
                            held--;
                        end
                    end
                end
            endcase
            reply.occupancy = CNT_W'(held);
            owed_replies.push_back(reply);
        endfunction

        function void check_result(logic [VALUE_W-1:0] result_value,
                                   logic [STATUS_W-1:0] status, logic [CNT_W-1:0] occupancy);
            deque_reply_t want;

            if (owed_replies.size() == 0)
            begin
                $error("unexpected result word: result_value %h status %0d occupancy %0d",
                       result_value, status, occupancy);
                errors++;
                return;
            end
            want = owed_replies.pop_front();
            if (result_value !== want.result_value)
            begin
                $error("result_value mismatch: expected %h actual %h",
                       want.result_value, result_value);
                errors++;
            end
            if (status !== want.status)
            begin
                $error("status mismatch: expected %0d actual %0d", want.status, status);
                errors++;
            end
            if (occupancy !== want.occupancy)
            begin
                $error("occupancy mismatch: expected %0d actual %0d",
                       want.occupancy, occupancy);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    int unsigned quiet_cycles;
    deque_scoreboard sb;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_search_remove_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [MODE_W-1:0] mode_of(op_t op, bit from_tail);
        return {op, from_tail};
    endfunction

    function automatic int unsigned draw_idle();
        return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // many small words so searches find duplicates, with zero and the extremes mixed in
    function automatic logic [VALUE_W-1:0] draw_word();
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        else if (pick < 35)
            return VALUE_W'($urandom_range(1, 6));
        else if (pick < 40)
            return '1;
        else if (pick < 45)
            return {1'b1, {(VALUE_W-1){1'b0}}};
        else
            return $urandom;
    endfunction

    // present one word and hold it until accepted; valid is left high
    task automatic send_word(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                             logic [IDX_W-1:0] index);
        bit taken;

        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.value <= value;
        req_ch.index <= index;
        do
        begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        sb.note_request(mode, value, index);
    endtask

    // gap after an accepted word, optionally until every reply has come back
    task automatic hold_off(int unsigned cycles, bit drain);
        if (cycles > 0 || drain)
            req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
        if (drain)
        begin
            while (sb.owed() != 0)
                @(posedge clk);
        end
    endtask

    task automatic send_then_idle(op_t op, bit from_tail, logic [VALUE_W-1:0] value,
                                  logic [IDX_W-1:0] index);
        send_word(mode_of(op, from_tail), value, index);
        hold_off(draw_idle(), 1'b0);
    endtask

    task automatic run_directed();
        // empty store: pops, peeks and a search all miss
        send_then_idle(OP_POP, END_HEAD, 32'h0000_0000, 6'd0);
        send_then_idle(OP_POP, END_TAIL, 32'hFFFF_FFFF, 6'd63);
        send_then_idle(OP_PEEK, END_HEAD, 32'h0000_0000, 6'd0);
        send_then_idle(OP_PEEK, END_TAIL, 32'h0000_0000, 6'd63);
        send_then_idle(OP_REMOVE, END_HEAD, 32'h1234_5678, 6'd0);
        // zero word is rejected for pushes and searches
        send_then_idle(OP_PUSH, END_HEAD, 32'h0000_0000, 6'd0);
        send_then_idle(OP_PUSH, END_TAIL, 32'h0000_0000, 6'd0);
        send_then_idle(OP_REMOVE, END_HEAD, 32'h0000_0000, 6'd0);
        send_then_idle(OP_REMOVE, END_TAIL, 32'h0000_0000, 6'd63);
        send_then_idle(OP_PUSH, END_HEAD, 32'hFFFF_FFFF, 6'd63);
        send_then_idle(OP_PUSH, END_TAIL, 32'h0000_0001, 6'd0);
        send_then_idle(OP_PUSH, END_HEAD, 32'h8000_0000, 6'd0);
        send_then_idle(OP_PUSH, END_TAIL, 32'h5A5A_A5A5, 6'd0);
        send_then_idle(OP_PEEK, END_HEAD, 32'h0000_0000, 6'd0);
        send_then_idle(OP_PEEK, END_TAIL, 32'h0000_0000, 6'd0);
        send_then_idle(OP_PEEK, END_HEAD, 32'h0000_0000, 6'd3);
        send_then_idle(OP_PEEK, END_HEAD, 32'h0000_0000, 6'd4);
        send_then_idle(OP_PEEK, END_TAIL, 32'h0000_0000, 6'd63);
        send_then_idle(OP_REMOVE, END_TAIL, 32'h0000_0001, 6'd0);
        send_then_idle(OP_REMOVE, END_HEAD, 32'hDEAD_BEEF, 6'd0);
        send_then_idle(OP_REMOVE, END_HEAD, 32'hFFFF_FFFF, 6'd0);
        send_then_idle(OP_POP, END_HEAD, 32'h0000_0000, 6'd0);
        send_then_idle(OP_POP, END_TAIL, 32'h0000_0000, 6'd0);
    endtask

    task automatic run_random(int unsigned words);
        int unsigned      lean;
        int unsigned      pick;
        int unsigned      push_cut;
        int unsigned      pop_cut;
        int unsigned      peek_cut;
        op_t              op;
        bit               from_tail;
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   index;

        lean = 0;
        for (int unsigned n = 0; n < words; n++)
        begin
            // lean towards filling, draining or neither, so full and empty both come up
            if (n % 200 == 0)
                lean = $urandom_range(0, 2);
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            push_cut = (lean == 0) ? 60 : (lean == 1) ? 20 : 35;
            pop_cut  = push_cut + ((lean == 1) ? 40 : 15);
            peek_cut = pop_cut + 18;
            pick = $urandom_range(0, 99);
            if (pick < push_cut)
                op = OP_PUSH;
            else if (pick < pop_cut)
                op = OP_POP;
            else if (pick < peek_cut)
                op = OP_PEEK;
            else
                op = OP_REMOVE;
            from_tail = 1'($urandom_range(0, 1));
            value     = draw_word();
            if (op == OP_REMOVE && sb.held > 0 && $urandom_range(0, 99) < 65)
                value = sb.word_at($urandom_range(0, sb.held - 1));
            if (sb.held > 0 && $urandom_range(0, 1) == 1)
                index = IDX_W'($urandom_range(0, sb.held - 1));
            else
                index = IDX_W'($urandom_range(0, 63));
            send_word(mode_of(op, from_tail), value, index);
            hold_off(draw_idle(), (n % 400 == 399));
        end
    endtask

    // result side: random stall before each word, then take it and check it
    initial
    begin
        bit          seen;
        int unsigned stall;

        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_idle();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                seen = rsp_ch.valid;
                if (seen)
                    sb.check_result(rsp_ch.result_value, rsp_ch.status, rsp_ch.occupancy);
                @(posedge clk);
            end
            while (!seen);
        end
    end

    // watchdog on cycles where neither channel moves a word
    always @(negedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        sb           = new();
        no_idle      = 1'b0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode  <= '0;
        req_ch.value <= '0;
        req_ch.index <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        hold_off(0, 1'b1);
        run_random(RANDOM_WORDS);
        hold_off(0, 1'b1);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* bounded_deque_with_search_remove_top.f */
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_req_if.sv
hw/rtl/bdq_rsp_if.sv
hw/rtl/bdq_ram.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bounded_deque_with_search_remove_top.sv
dv/tb_top.sv
